// ===== rtl/core/elfv_pkg.sv =====
// Package with the shared types, constants and state codes of the ELF image validator.
package elfv_pkg;

  localparam int AddrW = 16;
  localparam int LenW = AddrW + 1;
  localparam int BufBytes = 52;
  localparam int CntW = 6;

  localparam logic [31:0] RuntimeBytesMax = 32'd262144;
  localparam logic [7:0] HdrBytes = 8'd52;
  localparam logic [7:0] PhBytes = 8'd32;
  localparam logic [7:0] ShBytes = 8'd40;
  localparam logic [15:0] MachineId = 16'd94;
  localparam logic [15:0] TypeShared = 16'd3;
  localparam logic [31:0] SecNobits = 32'd8;
  localparam logic [31:0] SegLoad = 32'd1;
  localparam logic [7:0] Mag0 = 8'h7f;
  localparam logic [7:0] Mag1 = 8'h45;
  localparam logic [7:0] Mag2 = 8'h4c;
  localparam logic [7:0] Mag3 = 8'h46;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_LIMIT = 2'd1;
  localparam logic [1:0] ST_ELF = 2'd2;

  typedef struct packed {
    logic [7:0] image_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] runtime_total;
  } out_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  typedef enum logic [3:0] {
    S_LOAD, S_LIMIT, S_HDR_RD, S_HDR_CHK, S_TBL_CHK, S_PH_RD, S_PH_CHK,
    S_SH0_RD, S_SH0_CHK, S_SH_RD, S_SH_CHK, S_FINAL
  } state_t;

  function automatic logic is_pow2(input logic [31:0] v);
    is_pow2 = (v != 32'd0) && ((v & (v - 32'd1)) == 32'd0);
  endfunction

endpackage

// ===== rtl/core/elfv_store.sv =====
// Byte store of the image with one write port and one registered read port.
module elfv_store (
  input  logic               clk,
  input  elfv_pkg::mem_req_t req,
  output logic [7:0]         rdata
);

  logic [7:0] mem [2**elfv_pkg::AddrW];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ===== rtl/core/elfv_seq.sv =====
// Load control and check sequencer that walks the stored image and forms the result.
module elfv_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  elfv_pkg::in_t      item,
  input  logic [31:0]        limit,
  input  logic [7:0]         rdata,
  output elfv_pkg::mem_req_t req,
  output logic               busy,
  output logic               done,
  output elfv_pkg::out_t     result
);

  elfv_pkg::state_t state, state_next;
  logic [elfv_pkg::LenW-1:0] len;
  logic too_long, seg_seen, sec_seen;
  logic [31:0] sum;
  logic [15:0] ecnt;
  logic [elfv_pkg::AddrW-1:0] base;
  logic [elfv_pkg::CntW-1:0] cnt, rd_len, roff;
  logic rvalid;
  logic [8*elfv_pkg::BufBytes-1:0] ebuf;
  logic [31:0] ph_off, sh_off;
  logic [15:0] ph_cnt, sh_cnt, str_idx;

  logic accept, rd_state, rd_done, issue, fin;
  logic [1:0] fin_status;
  logic [32:0] n33;
  logic hdr_bad, tbl_bad, ph_bad, ph_load, sh_bad, sh_exec;
  logic [32:0] ph_end, sh_end, seg_end, sec_end, add33;
  logic [31:0] p_type, p_foff, p_vaddr, p_fsz, p_msz, p_flg, p_al;
  logic [31:0] s_type, s_flg, s_foff, s_sz, s_al;

  assign accept = start && !busy;
  assign busy = (state != elfv_pkg::S_LOAD);
  assign n33 = 33'(len);
  assign rd_state = (state == elfv_pkg::S_HDR_RD) || (state == elfv_pkg::S_PH_RD) ||
                    (state == elfv_pkg::S_SH0_RD) || (state == elfv_pkg::S_SH_RD);
  assign rd_done = (cnt == rd_len) && !rvalid;

  always_comb begin
    hdr_bad = (len < elfv_pkg::LenW'(elfv_pkg::HdrBytes)) ||
              (ebuf[7:0] != elfv_pkg::Mag0) || (ebuf[15:8] != elfv_pkg::Mag1) ||
              (ebuf[23:16] != elfv_pkg::Mag2) || (ebuf[31:24] != elfv_pkg::Mag3) ||
              (ebuf[39:32] != 8'd1) || (ebuf[47:40] != 8'd1) || (ebuf[55:48] != 8'd1) ||
              (ebuf[8*16 +: 16] != elfv_pkg::TypeShared) ||
              (ebuf[8*18 +: 16] != elfv_pkg::MachineId) ||
              (ebuf[8*20 +: 32] != 32'd1) ||
              (ebuf[8*40 +: 16] != 16'(elfv_pkg::HdrBytes)) ||
              (ebuf[8*42 +: 16] != 16'(elfv_pkg::PhBytes)) ||
              (ebuf[8*46 +: 16] != 16'(elfv_pkg::ShBytes));
  end

  always_comb begin
    ph_end = 33'(ph_off) + {12'd0, ph_cnt, 5'd0};
    sh_end = 33'(sh_off) + {12'd0, ph_cnt & 16'd0, 5'd0} + {12'd0, sh_cnt, 5'd0} +
             {14'd0, sh_cnt, 3'd0};
    tbl_bad = (ph_cnt == 16'd0) || (sh_cnt < 16'd2) ||
              (ph_off < 32'(elfv_pkg::HdrBytes)) || (sh_off < 32'(elfv_pkg::HdrBytes)) ||
              (33'(ph_off) > n33) || (ph_end > n33) ||
              (33'(sh_off) > n33) || (sh_end > n33) ||
              ((str_idx != 16'd0) && (str_idx >= sh_cnt));
  end

  always_comb begin
    p_type = ebuf[0 +: 32];
    p_foff = ebuf[32 +: 32];
    p_vaddr = ebuf[64 +: 32];
    p_fsz = ebuf[128 +: 32];
    p_msz = ebuf[160 +: 32];
    p_flg = ebuf[192 +: 32];
    p_al = ebuf[224 +: 32];
    seg_end = 33'(p_foff) + 33'(p_fsz);
    add33 = 33'(sum) + 33'(p_msz);
    ph_load = (p_type == elfv_pkg::SegLoad);
    ph_bad = ph_load && ((p_fsz > p_msz) || (33'(p_foff) > n33) || (seg_end > n33) ||
             ((p_al > 32'd1) && (!elfv_pkg::is_pow2(p_al) ||
              (((p_foff ^ p_vaddr) & (p_al - 32'd1)) != 32'd0))) || add33[32]);
  end

  always_comb begin
    s_type = ebuf[32 +: 32];
    s_flg = ebuf[64 +: 32];
    s_foff = ebuf[128 +: 32];
    s_sz = ebuf[160 +: 32];
    s_al = ebuf[256 +: 32];
    sec_end = 33'(s_foff) + 33'(s_sz);
    sh_bad = ((s_type != elfv_pkg::SecNobits) &&
              ((33'(s_foff) > n33) || (sec_end > n33))) ||
             ((s_al > 32'd1) && !elfv_pkg::is_pow2(s_al));
    sh_exec = (s_flg[2:1] == 2'b11) && (s_type != elfv_pkg::SecNobits) && (s_sz != 32'd0);
  end

  always_comb begin
    state_next = state;
    case (state)
      elfv_pkg::S_LOAD: begin
        if (accept && item.last_byte) state_next = elfv_pkg::S_LIMIT;
      end
      elfv_pkg::S_LIMIT: begin
        state_next = fin ? elfv_pkg::S_LOAD : elfv_pkg::S_HDR_RD;
      end
      elfv_pkg::S_HDR_RD: begin
        if (rd_done) state_next = elfv_pkg::S_HDR_CHK;
      end
      elfv_pkg::S_HDR_CHK: begin
        state_next = fin ? elfv_pkg::S_LOAD : elfv_pkg::S_TBL_CHK;
      end
      elfv_pkg::S_TBL_CHK: begin
        state_next = fin ? elfv_pkg::S_LOAD : elfv_pkg::S_PH_RD;
      end
      elfv_pkg::S_PH_RD: begin
        if (rd_done) state_next = elfv_pkg::S_PH_CHK;
      end
      elfv_pkg::S_PH_CHK: begin
        if (fin) state_next = elfv_pkg::S_LOAD;
        else if (ecnt + 16'd1 == ph_cnt) state_next = elfv_pkg::S_SH0_RD;
        else state_next = elfv_pkg::S_PH_RD;
      end
      elfv_pkg::S_SH0_RD: begin
        if (rd_done) state_next = elfv_pkg::S_SH0_CHK;
      end
      elfv_pkg::S_SH0_CHK: begin
        state_next = fin ? elfv_pkg::S_LOAD : elfv_pkg::S_SH_RD;
      end
      elfv_pkg::S_SH_RD: begin
        if (rd_done) state_next = elfv_pkg::S_SH_CHK;
      end
      elfv_pkg::S_SH_CHK: begin
        if (fin) state_next = elfv_pkg::S_LOAD;
        else if (ecnt + 16'd1 == sh_cnt) state_next = elfv_pkg::S_FINAL;
        else state_next = elfv_pkg::S_SH_RD;
      end
      elfv_pkg::S_FINAL: begin
        state_next = elfv_pkg::S_LOAD;
      end
      default: begin
        state_next = elfv_pkg::S_LOAD;
      end
    endcase
  end

  always_comb begin
    issue = rd_state && (cnt < rd_len);
    req.we = accept && !len[elfv_pkg::LenW-1];
    req.waddr = len[elfv_pkg::AddrW-1:0];
    req.wdata = item.image_byte;
    req.re = issue;
    req.raddr = base + elfv_pkg::AddrW'(cnt);
    fin = 1'b0;
    fin_status = elfv_pkg::ST_OK;
    case (state)
      elfv_pkg::S_LIMIT: begin
        if (too_long || (limit == 32'd0) || (limit > elfv_pkg::RuntimeBytesMax)) begin
          fin = 1'b1;
          fin_status = elfv_pkg::ST_LIMIT;
        end
      end
      elfv_pkg::S_HDR_CHK: begin
        fin = hdr_bad;
        fin_status = elfv_pkg::ST_ELF;
      end
      elfv_pkg::S_TBL_CHK: begin
        fin = tbl_bad;
        fin_status = elfv_pkg::ST_ELF;
      end
      elfv_pkg::S_PH_CHK: begin
        fin = ph_bad;
        fin_status = elfv_pkg::ST_ELF;
      end
      elfv_pkg::S_SH0_CHK: begin
        fin = (s_type != 32'd0) || (s_flg != 32'd0);
        fin_status = elfv_pkg::ST_ELF;
      end
      elfv_pkg::S_SH_CHK: begin
        fin = sh_bad;
        fin_status = elfv_pkg::ST_ELF;
      end
      elfv_pkg::S_FINAL: begin
        fin = 1'b1;
        if (!seg_seen || !sec_seen) fin_status = elfv_pkg::ST_ELF;
        else if ((sum == 32'd0) || (sum > limit)) fin_status = elfv_pkg::ST_LIMIT;
        else fin_status = elfv_pkg::ST_OK;
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= elfv_pkg::S_LOAD;
      len <= '0;
      too_long <= 1'b0;
      sum <= '0;
      seg_seen <= 1'b0;
      sec_seen <= 1'b0;
      ecnt <= '0;
      cnt <= '0;
      rvalid <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= fin;
      rvalid <= issue;
      if (issue) begin
        cnt <= cnt + elfv_pkg::CntW'(1);
      end
      if (state_next != state) begin
        cnt <= '0;
      end
      if (accept) begin
        if (len[elfv_pkg::LenW-1]) too_long <= 1'b1;
        else len <= len + elfv_pkg::LenW'(1);
      end
      if ((state == elfv_pkg::S_PH_CHK) && ph_load && !ph_bad) begin
        sum <= add33[31:0];
        if (p_flg[0] && (p_fsz != 32'd0)) seg_seen <= 1'b1;
      end
      if ((state == elfv_pkg::S_SH_CHK) && !sh_bad && sh_exec) begin
        sec_seen <= 1'b1;
      end
      if (fin) begin
        ecnt <= '0;
      end else begin
        case (state)
          elfv_pkg::S_TBL_CHK: ecnt <= '0;
          elfv_pkg::S_PH_CHK: ecnt <= ecnt + 16'd1;
          elfv_pkg::S_SH0_CHK: ecnt <= 16'd1;
          elfv_pkg::S_SH_CHK: ecnt <= ecnt + 16'd1;
          default: ecnt <= ecnt;
        endcase
      end
      if (fin) begin
        len <= '0;
        too_long <= 1'b0;
        sum <= '0;
        seg_seen <= 1'b0;
        sec_seen <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      roff <= cnt;
    end
    if (rvalid) begin
      ebuf[8*roff +: 8] <= rdata;
    end
    case (state_next)
      elfv_pkg::S_HDR_RD: rd_len <= elfv_pkg::CntW'(elfv_pkg::HdrBytes);
      elfv_pkg::S_PH_RD: rd_len <= elfv_pkg::CntW'(elfv_pkg::PhBytes);
      elfv_pkg::S_SH0_RD: rd_len <= elfv_pkg::CntW'(elfv_pkg::ShBytes);
      elfv_pkg::S_SH_RD: rd_len <= elfv_pkg::CntW'(elfv_pkg::ShBytes);
      default: rd_len <= rd_len;
    endcase
    case (state)
      elfv_pkg::S_LIMIT: base <= '0;
      elfv_pkg::S_HDR_CHK: begin
        ph_off <= ebuf[8*28 +: 32];
        sh_off <= ebuf[8*32 +: 32];
        ph_cnt <= ebuf[8*44 +: 16];
        sh_cnt <= ebuf[8*48 +: 16];
        str_idx <= ebuf[8*50 +: 16];
      end
      elfv_pkg::S_TBL_CHK: base <= ph_off[elfv_pkg::AddrW-1:0];
      elfv_pkg::S_PH_CHK: begin
        if (ecnt + 16'd1 == ph_cnt) base <= sh_off[elfv_pkg::AddrW-1:0];
        else base <= base + elfv_pkg::AddrW'(elfv_pkg::PhBytes);
      end
      elfv_pkg::S_SH0_CHK: base <= base + elfv_pkg::AddrW'(elfv_pkg::ShBytes);
      elfv_pkg::S_SH_CHK: base <= base + elfv_pkg::AddrW'(elfv_pkg::ShBytes);
      default: base <= base;
    endcase
    if (fin) begin
      result.status <= fin_status;
      result.runtime_total <= (fin_status == elfv_pkg::ST_OK) ? sum : 32'd0;
    end
  end

endmodule

// ===== rtl/core/elf32_image_validator.sv =====
// Top level of the ELF image validator: configuration register, byte store and sequencer.
// Loading takes one byte word per cycle; busy stays low until the last byte is taken.
// The check walk then reads the header, each program header entry and each section header
// entry from the byte store through its one read port, once per cycle while in a read state.
// The result strobe comes in the cycle after the final check; the receiver cannot stall it.
// Synchronous reset clears the control state and the limit register; the store is not cleared.
module elf32_image_validator (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  elfv_pkg::in_t  item,
  output logic           done,
  output elfv_pkg::out_t result,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  logic [31:0] limit;
  elfv_pkg::mem_req_t req;
  logic [7:0] rdata;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= '0;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      limit <= pwdata;
    end
  end

  elfv_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  elfv_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .limit  (limit),
    .rdata  (rdata),
    .req    (req),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without a check walk");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy while the result is shown");

  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && (result.status == elfv_pkg::ST_OK) |-> result.runtime_total != 32'd0)
    else $error("ok status with an empty sum");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == elfv_pkg::ST_OK) || (result.status == elfv_pkg::ST_LIMIT) ||
             (result.status == elfv_pkg::ST_ELF)) else $error("bad status code");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the ELF32 image validator: streamed images against a predictor.
`timescale 1ns / 100ps

module tb_top;
  import elfv_pkg::*;

  typedef enum int {
    M_NONE, M_MAGIC, M_CLASS, M_MACHINE, M_SHORT, M_PHCOUNT0, M_TBL_OVER, M_STRIDX,
    M_FSZ_GT_MSZ, M_ALIGN, M_CONGR, M_OVERFLOW, M_SH0, M_NOEXEC_SEG, M_NOEXEC_SEC,
    M_ZERO_SUM, M_BYTEFLIP, M_NOISE, M_PADMAX, M_OVERLONG
  } flaw_t;

  typedef struct {
    flaw_t       flaw;
    logic [31:0] limit;
    bit          typed;
    logic [1:0]  status;
  } row_t;

  localparam int IdleLimit = 20000;
  localparam int MaxBytes = 65536;

  logic clk, rst, start, busy, done;
  in_t item;
  out_t result;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  logic [7:0] image[$];
  int ph_cnt, sh_cnt, sh_off;
  out_t expected_results[$];
  logic [31:0] limit_reg;
  int errors, images_sent, results_seen, bytes_sent, idle_cycles;
  bit no_idle;

  elf32_image_validator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item), .done(done),
    .result(result), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [31:0] rd8(longint unsigned pos);
    return (pos < image.size()) ? {24'd0, image[pos]} : 32'd0;
  endfunction

  function automatic logic [31:0] rd16(longint unsigned pos);
    return rd8(pos) | (rd8(pos + 1) << 8);
  endfunction

  function automatic logic [31:0] rd32(longint unsigned pos);
    return rd16(pos) | (rd16(pos + 2) << 16);
  endfunction

  function automatic bit fits(longint unsigned n, longint unsigned s, longint unsigned l);
    return s <= n && l <= n - s;
  endfunction

  function automatic bit pow2(logic [31:0] v);
    return v != 0 && (v & (v - 1)) == 0;
  endfunction

  function automatic logic [1:0] walk_checks(logic [31:0] lim, output logic [31:0] sum);
    longint unsigned n, e;
    logic [31:0] ph_o, sh_o, phn, shn, sidx, ty, foff, va, fsz, msz, flg, al;
    bit seg_x, sec_x;
    n = image.size();
    sum = 0;
    seg_x = 0;
    sec_x = 0;
    if (n > MaxBytes || lim == 0 || lim > RuntimeBytesMax) return ST_LIMIT;
    if (n < 52 || rd8(0) != Mag0 || rd8(1) != Mag1 || rd8(2) != Mag2 || rd8(3) != Mag3 ||
        rd8(4) != 1 || rd8(5) != 1 || rd8(6) != 1 || rd16(16) != TypeShared ||
        rd16(18) != MachineId || rd32(20) != 1 || rd16(40) != HdrBytes ||
        rd16(42) != PhBytes || rd16(46) != ShBytes)
      return ST_ELF;
    ph_o = rd32(28);
    sh_o = rd32(32);
    phn = rd16(44);
    shn = rd16(48);
    sidx = rd16(50);
    if (phn == 0 || shn < 2 || ph_o < HdrBytes || sh_o < HdrBytes ||
        !fits(n, ph_o, longint'(phn) * PhBytes) || !fits(n, sh_o, longint'(shn) * ShBytes) ||
        (sidx != 0 && sidx >= shn))
      return ST_ELF;
    for (int i = 0; i < phn; i++) begin
      e = longint'(ph_o) + longint'(i) * PhBytes;
      ty = rd32(e);
      foff = rd32(e + 4);
      va = rd32(e + 8);
      fsz = rd32(e + 16);
      msz = rd32(e + 20);
      flg = rd32(e + 24);
      al = rd32(e + 28);
      if (ty != SegLoad) continue;
      if (fsz > msz || !fits(n, foff, fsz) ||
          (al > 1 && (!pow2(al) || (foff & (al - 1)) != (va & (al - 1)))) ||
          msz > 32'hffff_ffff - sum)
        return ST_ELF;
      sum += msz;
      if (flg[0] && fsz != 0) seg_x = 1;
    end
    if (rd32(longint'(sh_o) + 4) != 0 || rd32(longint'(sh_o) + 8) != 0) return ST_ELF;
    for (int i = 1; i < shn; i++) begin
      e = longint'(sh_o) + longint'(i) * ShBytes;
      ty = rd32(e + 4);
      flg = rd32(e + 8);
      foff = rd32(e + 16);
      fsz = rd32(e + 20);
      al = rd32(e + 32);
      if ((ty != SecNobits && !fits(n, foff, fsz)) || (al > 1 && !pow2(al))) return ST_ELF;
      if ((flg & 6) == 6 && ty != SecNobits && fsz != 0) sec_x = 1;
    end
    if (!seg_x || !sec_x) return ST_ELF;
    if (sum == 0 || sum > lim) return ST_LIMIT;
    return ST_OK;
  endfunction

  function automatic out_t predict_result(logic [31:0] lim);
    out_t r;
    logic [31:0] sum;
    r.status = walk_checks(lim, sum);
    r.runtime_total = (r.status == ST_OK) ? sum : 32'd0;
    return r;
  endfunction

  function automatic void put16(int pos, logic [31:0] v);
    image[pos] = v[7:0];
    image[pos + 1] = v[15:8];
  endfunction

  function automatic void put32(int pos, logic [31:0] v);
    put16(pos, v);
    put16(pos + 2, v >> 16);
  endfunction

  function automatic logic [31:0] pick_align();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'd4;
      3: return 32'd16;
      default: return 32'd64;
    endcase
  endfunction

  function automatic void build_image(flaw_t flaw);
    int pay, plen, n, e, k;
    logic [31:0] al, foff, fsz;
    ph_cnt = $urandom_range(1, 3);
    sh_cnt = $urandom_range(2, 4);
    plen = $urandom_range(16, 96);
    sh_off = 52 + 32 * ph_cnt;
    pay = sh_off + 40 * sh_cnt;
    n = pay + plen;
    image.delete();
    for (int i = 0; i < n; i++) image.push_back(8'($urandom));
    image[0] = Mag0;
    image[1] = Mag1;
    image[2] = Mag2;
    image[3] = Mag3;
    image[4] = 8'd1;
    image[5] = 8'd1;
    image[6] = 8'd1;
    put16(16, TypeShared);
    put16(18, MachineId);
    put32(20, 32'd1);
    put32(28, 32'd52);
    put32(32, sh_off);
    put16(40, HdrBytes);
    put16(42, PhBytes);
    put16(44, ph_cnt);
    put16(46, ShBytes);
    put16(48, sh_cnt);
    put16(50, $urandom_range(0, sh_cnt - 1));
    for (int i = 0; i < ph_cnt; i++) begin
      e = 52 + 32 * i;
      al = pick_align();
      foff = pay + $urandom_range(0, plen - 16);
      fsz = $urandom_range(1, 16);
      put32(e, (i == 0 || $urandom_range(0, 2) != 0) ? SegLoad : 32'd2);
      put32(e + 4, foff);
      put32(e + 8, (al > 1) ? (($urandom & ~(al - 1)) | (foff & (al - 1))) : $urandom);
      put32(e + 16, fsz);
      put32(e + 20, fsz + $urandom_range(0, 512));
      put32(e + 24, (i == 0) ? 32'd5 : $urandom);
      put32(e + 28, al);
    end
    for (int i = 0; i < 40; i++) image[sh_off + i] = 8'd0;
    for (int i = 1; i < sh_cnt; i++) begin
      e = sh_off + 40 * i;
      put32(e + 4, $urandom_range(0, 1) ? SecNobits : 32'd1);
      if (i == 1) put32(e + 4, 32'd1);
      put32(e + 8, (i == 1) ? 32'd6 : $urandom);
      put32(e + 16, pay + $urandom_range(0, plen - 16));
      put32(e + 20, $urandom_range(1, 16));
      put32(e + 32, pick_align());
    end
    case (flaw)
      M_MAGIC: image[$urandom_range(0, 3)] = 8'h00;
      M_CLASS: image[4] = 8'd2;
      M_MACHINE: put16(18, 32'd3);
      M_SHORT: begin
        k = $urandom_range(1, 51);
        while (image.size() > k) void'(image.pop_back());
      end
      M_PHCOUNT0: put16(44, 32'd0);
      M_TBL_OVER: put16(48, 32'hffff);
      M_STRIDX: put16(50, sh_cnt);
      M_FSZ_GT_MSZ: put32(72, rd32(68) - 1);
      M_ALIGN: put32(80, 32'd3);
      M_CONGR: begin
        put32(80, 32'd16);
        put32(60, rd32(56) + 1);
      end
      M_OVERFLOW: for (int i = 0; i < ph_cnt; i++) put32(72 + 32 * i, 32'hffff_fff0);
      M_SH0: put32(sh_off + 4 + 4 * $urandom_range(0, 1), $urandom_range(1, 255));
      M_NOEXEC_SEG: for (int i = 0; i < ph_cnt; i++) image[76 + 32 * i][0] = 1'b0;
      M_NOEXEC_SEC: for (int i = 1; i < sh_cnt; i++) put32(sh_off + 40 * i + 8, 32'd0);
      M_ZERO_SUM: for (int i = 0; i < ph_cnt; i++) begin
        put32(68 + 32 * i, 32'd0);
        put32(72 + 32 * i, 32'd0);
      end
      M_BYTEFLIP: image[$urandom_range(0, n - 1)] = 8'($urandom);
      M_NOISE: begin
        k = $urandom_range(1, 80);
        image.delete();
        for (int i = 0; i < k; i++) image.push_back(8'($urandom));
      end
      M_PADMAX: while (image.size() < MaxBytes) image.push_back(8'($urandom));
      M_OVERLONG: while (image.size() < MaxBytes + 1) image.push_back(8'($urandom));
      default: ;
    endcase
  endfunction

  function automatic int gap_len();
    if (no_idle || $urandom_range(0, 9) < 7) return 0;
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  task automatic write_limit(logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'd0;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    limit_reg = v;
  endtask

  task automatic send_image();
    int g;
    for (int i = 0; i < image.size(); i++) begin
      start <= 1'b1;
      item <= '{image_byte: image[i], last_byte: (i == image.size() - 1)};
      do @(posedge clk); while (busy);
      bytes_sent++;
      g = gap_len();
      if ((i == image.size() - 1) && (g == 0)) g = 1;
      if (g > 0) begin
        start <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
    images_sent++;
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word", result.runtime_total, 32'd0);
      end else begin
        if (result.status != expected_results[0].status)
          report_mismatch("status", 32'(result.status), 32'(expected_results[0].status));
        if (result.runtime_total != expected_results[0].runtime_total)
          report_mismatch("runtime_total", result.runtime_total,
                          expected_results[0].runtime_total);
        void'(expected_results.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Watchdog expired after %0d idle cycles", IdleLimit);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  row_t rows[] = '{
    '{M_NONE, 32'd0, 1, ST_LIMIT},
    '{M_MAGIC, 32'd0, 1, ST_LIMIT},
    '{M_NONE, 32'd4096, 0, ST_OK},
    '{M_NONE, 32'd4096, 0, ST_OK},
    '{M_MAGIC, 32'd4096, 1, ST_ELF},
    '{M_CLASS, 32'd4096, 1, ST_ELF},
    '{M_MACHINE, 32'd4096, 1, ST_ELF},
    '{M_SHORT, 32'd4096, 1, ST_ELF},
    '{M_PHCOUNT0, 32'd4096, 1, ST_ELF},
    '{M_TBL_OVER, 32'd4096, 1, ST_ELF},
    '{M_STRIDX, 32'd4096, 1, ST_ELF},
    '{M_FSZ_GT_MSZ, 32'd4096, 1, ST_ELF},
    '{M_ALIGN, 32'd4096, 1, ST_ELF},
    '{M_CONGR, 32'd4096, 1, ST_ELF},
    '{M_SH0, 32'd4096, 1, ST_ELF},
    '{M_NOEXEC_SEG, 32'd4096, 1, ST_ELF},
    '{M_NOEXEC_SEC, 32'd4096, 1, ST_ELF},
    '{M_ZERO_SUM, 32'd4096, 1, ST_ELF},
    '{M_OVERFLOW, 32'd262144, 0, ST_OK},
    '{M_NONE, 32'd1, 0, ST_LIMIT},
    '{M_NONE, 32'd262145, 1, ST_LIMIT},
    '{M_NONE, 32'hffff_ffff, 1, ST_LIMIT},
    '{M_PADMAX, 32'd262144, 0, ST_OK},
    '{M_OVERLONG, 32'd262144, 1, ST_LIMIT},
    '{M_NOISE, 32'd262144, 0, ST_OK}
  };

  initial begin
    logic [31:0] limits[6];
    flaw_t flaw;
    out_t want;
    limits = '{32'd1, 32'd4096, 32'd262144, 32'd262145, 32'hffff_ffff, 32'd0};
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    limit_reg = 32'd0;
    errors = 0;
    images_sent = 0;
    results_seen = 0;
    bytes_sent = 0;
    no_idle = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[r]) begin
      if (rows[r].limit != limit_reg) write_limit(rows[r].limit);
      no_idle = $urandom_range(0, 2) == 0;
      build_image(rows[r].flaw);
      if (rows[r].typed) want = '{status: rows[r].status, runtime_total: 32'd0};
      else want = predict_result(limit_reg);
      expected_results.push_back(want);
      send_image();
      drain();
    end

    while (images_sent < rows.size() + 60 || bytes_sent < 1150) begin
      if (images_sent % 10 == 0) begin
        drain();
        write_limit(($urandom_range(0, 3) == 0) ? limits[$urandom_range(0, 5)]
                                                : $urandom_range(1024, 262144));
      end
      flaw = ($urandom_range(0, 9) < 6) ? M_NONE : flaw_t'($urandom_range(M_MAGIC, M_NOISE));
      no_idle = $urandom_range(0, 3) == 0;
      build_image(flaw);
      expected_results.push_back(predict_result(limit_reg));
      send_image();
    end

    drain();
    repeat (200) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0d expected words never arrived", expected_results.size());
      errors++;
    end
    $display("Streamed %0d images (%0d bytes) and checked %0d result words.",
             images_sent, bytes_sent, results_seen);
    $display("Covered header, table, entry, sum and limit checks across several limits.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/elfv_pkg.sv
rtl/core/elfv_store.sv
rtl/core/elfv_seq.sv
rtl/core/elf32_image_validator.sv
tb/tb_top.sv
